[rtl/sart_pkg.sv]
// Shared package of the subnet access rule table: table size, request and
// status codes, the stored rule record and the controller/datapath link types.
// Depends on nothing.
package sart_pkg;

    localparam int RULE_ENTRIES = 32;
    localparam int IDX_W        = $clog2(RULE_ENTRIES);

    localparam logic [2:0] REQ_ADD_ALLOW = 3'd0;
    localparam logic [2:0] REQ_DEL_ALLOW = 3'd1;
    localparam logic [2:0] REQ_ADD_DENY  = 3'd2;
    localparam logic [2:0] REQ_DEL_DENY  = 3'd3;
    localparam logic [2:0] REQ_CHECK     = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_PRESENT    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
    localparam logic [2:0] ST_FULL       = 3'd3;
    localparam logic [2:0] ST_BAD_PREFIX = 3'd4;

    localparam logic [7:0] V4_MAX_PREFIX = 8'd32;
    localparam logic [7:0] V6_MAX_PREFIX = 8'd128;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic        deny;
        logic        v6;
        logic [7:0]  prefix;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
    } t_rule;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_en;
        t_idx rd_idx;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
    } t_sts;

endpackage

[rtl/sart_dp.sv]
// Datapath of the subnet access rule table: request registers, the rule
// memory with its valid bits, the per-entry compare stage and the result register.
// Depends on sart_pkg.
module sart_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sart_pkg::t_cmd       i_cmd,
    output sart_pkg::t_sts       o_sts,
    input  logic [2:0]           i_req_type,
    input  logic                 i_is_ipv6,
    input  logic [63:0]          i_addr_high,
    input  logic [63:0]          i_addr_low,
    input  logic [7:0]           i_prefix_len,
    output logic                 o_done,
    output logic [2:0]           o_status,
    output logic                 o_access_allowed
);

    // Mask of a prefix over the 128-bit address word; IPv4 lives in bits 31..0.
    function automatic logic [127:0] prefix_mask(input logic v6, input logic [7:0] p);
        logic [127:0] m;
        m = '0;
        for (int j = 0; j < 128; j++) begin
            if (v6) begin
                m[j] = (p > 8'(127 - j));
            end else if (j < 32) begin
                m[j] = (p > 8'(31 - j));
            end
        end
        return m;
    endfunction

    // Request registers.
    logic [2:0]   r_req;
    logic         r_v6;
    logic [127:0] r_key;
    logic [7:0]   r_prefix;
    logic         r_bad;

    // Rule memory, valid bits and the compare stage.
    sart_pkg::t_rule r_mem [sart_pkg::RULE_ENTRIES];
    sart_pkg::t_rule r_rd_data;
    logic [sart_pkg::RULE_ENTRIES-1:0] r_valid;
    logic            r_cmp_vld;
    sart_pkg::t_idx  r_cmp_idx;

    // Scan trackers.
    logic           r_hit_found;
    sart_pkg::t_idx r_hit_idx;
    logic           r_free_found;
    sart_pkg::t_idx r_free_idx;
    logic           r_allow_found;
    logic           r_deny_found;
    logic [7:0]     r_best_allow;
    logic [7:0]     r_best_deny;

    // Result registers.
    logic       r_done;
    logic [2:0] r_status;
    logic       r_allowed;

    logic [63:0]  w_fam_h;
    logic [63:0]  w_fam_l;
    logic [127:0] w_in_mask;
    logic         w_in_cfg;
    logic         w_known;
    logic         w_cfg;
    logic         w_kind_deny;
    logic         w_ent_vld;
    logic [127:0] w_ent_mask;
    logic         w_exact_hit;
    logic         w_check_hit;
    logic [2:0]   n_status;
    logic         n_allowed;
    logic         w_add_commit;
    logic         w_del_commit;

    // Input conditioning at accept time.
    assign w_fam_h   = i_is_ipv6 ? i_addr_high : 64'd0;
    assign w_fam_l   = i_is_ipv6 ? i_addr_low : {32'd0, i_addr_low[31:0]};
    assign w_in_mask = prefix_mask(i_is_ipv6, i_prefix_len);
    assign w_in_cfg  = i_req_type inside {[sart_pkg::REQ_ADD_ALLOW:sart_pkg::REQ_DEL_DENY]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= i_req_type;
            r_v6     <= i_is_ipv6;
            r_prefix <= i_prefix_len;
            r_bad    <= i_prefix_len > (i_is_ipv6 ? sart_pkg::V6_MAX_PREFIX
                                                  : sart_pkg::V4_MAX_PREFIX);
            r_key    <= w_in_cfg ? ({w_fam_h, w_fam_l} & w_in_mask) : {w_fam_h, w_fam_l};
        end
    end

    assign w_known     = r_req inside {[sart_pkg::REQ_ADD_ALLOW:sart_pkg::REQ_CHECK]};
    assign w_cfg       = r_req inside {[sart_pkg::REQ_ADD_ALLOW:sart_pkg::REQ_DEL_DENY]};
    assign w_kind_deny = r_req inside {sart_pkg::REQ_ADD_DENY, sart_pkg::REQ_DEL_DENY};
    assign o_sts.skip  = !w_known || (w_cfg && r_bad);

    // Memory: one registered read port for the scan, one write port at commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_idx];
        end
        if (w_add_commit) begin
            r_mem[r_free_idx] <= sart_pkg::t_rule'{
                deny:      w_kind_deny,
                v6:        r_v6,
                prefix:    r_prefix,
                addr_high: r_key[127:64],
                addr_low:  r_key[63:0]
            };
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
            if (w_add_commit) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (w_del_commit) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_cmp_idx <= i_cmd.rd_idx;
        end
    end

    // Compare stage: one stored rule per cycle.
    assign w_ent_vld   = r_valid[r_cmp_idx];
    assign w_ent_mask  = prefix_mask(r_v6, r_rd_data.prefix);
    assign w_exact_hit = w_ent_vld && (r_rd_data.deny == w_kind_deny)
                         && (r_rd_data.v6 == r_v6) && (r_rd_data.prefix == r_prefix)
                         && ({r_rd_data.addr_high, r_rd_data.addr_low} == r_key);
    assign w_check_hit = w_ent_vld && (r_rd_data.v6 == r_v6)
                         && ((r_key & w_ent_mask) == {r_rd_data.addr_high, r_rd_data.addr_low});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit_found   <= 1'b0;
            r_free_found  <= 1'b0;
            r_allow_found <= 1'b0;
            r_deny_found  <= 1'b0;
            r_best_allow  <= 8'd0;
            r_best_deny   <= 8'd0;
        end else if (r_cmp_vld) begin
            if (w_exact_hit && !r_hit_found) begin
                r_hit_found <= 1'b1;
                r_hit_idx   <= r_cmp_idx;
            end
            if (!w_ent_vld && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_cmp_idx;
            end
            if (w_check_hit && r_rd_data.deny) begin
                r_deny_found <= 1'b1;
                if (!r_deny_found || r_rd_data.prefix > r_best_deny) begin
                    r_best_deny <= r_rd_data.prefix;
                end
            end
            if (w_check_hit && !r_rd_data.deny) begin
                r_allow_found <= 1'b1;
                if (!r_allow_found || r_rd_data.prefix > r_best_allow) begin
                    r_best_allow <= r_rd_data.prefix;
                end
            end
        end
    end

    // Outcome of the request and the table update it causes.
    always_comb begin
        n_status     = sart_pkg::ST_OK;
        n_allowed    = 1'b0;
        w_add_commit = 1'b0;
        w_del_commit = 1'b0;
        case (r_req)
            sart_pkg::REQ_ADD_ALLOW, sart_pkg::REQ_ADD_DENY: begin
                if (r_bad) begin
                    n_status = sart_pkg::ST_BAD_PREFIX;
                end else if (r_hit_found) begin
                    n_status = sart_pkg::ST_PRESENT;
                end else if (!r_free_found) begin
                    n_status = sart_pkg::ST_FULL;
                end else begin
                    w_add_commit = i_cmd.finish;
                end
            end
            sart_pkg::REQ_DEL_ALLOW, sart_pkg::REQ_DEL_DENY: begin
                if (r_bad) begin
                    n_status = sart_pkg::ST_BAD_PREFIX;
                end else if (r_hit_found) begin
                    w_del_commit = i_cmd.finish;
                end else begin
                    n_status = sart_pkg::ST_NOT_FOUND;
                end
            end
            sart_pkg::REQ_CHECK: begin
                n_allowed = !r_deny_found
                            || (r_allow_found && (r_best_allow > r_best_deny));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_status  <= n_status;
            r_allowed <= n_allowed;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_access_allowed = r_allowed;

    a_add_to_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_commit |-> !r_valid[r_free_idx])
        else $error("add commits into an occupied entry");

    a_del_of_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_del_commit |-> r_valid[r_hit_idx])
        else $error("delete clears an entry that is not valid");

    a_scan_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !r_cmp_vld && !i_cmd.rd_en)
        else $error("result taken while the scan is still in flight");

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_commit |=> !w_add_commit && !w_del_commit)
        else $error("table written on two consecutive cycles");

endmodule

[rtl/sart_ctrl.sv]
// Controller of the subnet access rule table: accepts an item, steps the
// scan index over every entry unless the datapath signals a skip, and tells
// the datapath when to finish. Depends on sart_pkg.
module sart_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sart_pkg::t_sts i_sts,
    output sart_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam sart_pkg::t_idx LAST_IDX = sart_pkg::IDX_W'(sart_pkg::RULE_ENTRIES - 1);

    logic [1:0]     r_state;
    logic [1:0]     n_state;
    sart_pkg::t_idx r_idx;
    sart_pkg::t_idx n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (i_sts.skip) begin
                    n_state = S_DONE;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cmd.load    = start && !busy;
    assign o_cmd.rd_en   = (r_state == S_SCAN) && !i_sts.skip;
    assign o_cmd.rd_idx  = r_idx;
    assign o_cmd.finish  = (r_state == S_DONE);

    a_full_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> $past(r_idx) == LAST_IDX)
        else $error("drain entered before the last entry was read");

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> busy && r_idx == '0)
        else $error("accepted item did not start a scan at entry zero");

    a_finish_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> !o_cmd.finish && !busy)
        else $error("finish held for more than one cycle");

endmodule

[rtl/subnet_access_rule_table.sv]
// Top level of the subnet access rule table: an allow/deny subnet ACL with
// longest-prefix decisions. Instantiates sart_ctrl and sart_dp; uses sart_pkg.
//
//   Channel   Handshake               Item contents
//   -------   ---------------------   ------------------------------------------
//   request   start && !busy          i_req_type, i_is_ipv6, i_addr_high,
//                                     i_addr_low, i_prefix_len
//   result    o_done (one cycle)      o_status, o_access_allowed
//
// An accepted item keeps busy high while the controller reads every entry
// through the single read port of the rule memory, drains the compare stage and
// finishes. An add or delete with a bad prefix, or an unknown request, skips the
// scan and goes straight to the finish. o_done rises at the same edge at which
// busy falls, so the result is shown in the first cycle with busy low, and a new
// item may be accepted in that same cycle.
// Reset is synchronous and active low; it clears the controller, the pending
// result strobe and every valid bit, so the table comes up empty with no
// clearing pass. The receiver cannot stall: each result is shown once.
module subnet_access_rule_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic        i_is_ipv6,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    input  logic [7:0]  i_prefix_len,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic        o_access_allowed
);

    // The controller only sequences; all request fields, the rule memory
    // and the decision logic sit in the datapath.
    sart_pkg::t_cmd w_cmd;
    sart_pkg::t_sts w_sts;

    // The controller owns the scan index and the item handshake.
    sart_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // The datapath masks the address of an add or delete, compares one stored rule per
    // cycle, keeps the first exact hit, the lowest free entry and the longest
    // allow and deny matches, then updates the table and registers the result.
    sart_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_req_type       (i_req_type),
        .i_is_ipv6        (i_is_ipv6),
        .i_addr_high      (i_addr_high),
        .i_addr_low       (i_addr_low),
        .i_prefix_len     (i_prefix_len),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_access_allowed (o_access_allowed)
    );

endmodule

[sim/tb_top.sv]
// Self-checking testbench for subnet_access_rule_table: directed rows, then random add, delete
// and check traffic with sender idling, checked by an in-bench predictor or typed-in verdicts.
// Depends on sart_pkg and the subnet_access_rule_table RTL.
module tb_top;
    import sart_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * RULE_ENTRIES + 8;
    localparam int RANDOM_ITEMS   = 830;
    localparam int POOL_DEPTH     = 48;
    localparam int DIRECTED_COUNT = 26;

    // Request codes above REQ_CHECK are reserved and must be ignored by the block.
    localparam logic [2:0] REQ_RESERVED_A = REQ_CHECK + 3'd1;
    localparam logic [2:0] REQ_RESERVED_Z = 3'd7;

    typedef struct packed {
        logic [2:0] status;
        logic       allowed;
    } t_verdict;

    // One row of the directed list; when known is set, the verdict is typed in by hand.
    typedef struct packed {
        logic [2:0]  req;
        logic        v6;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [7:0]  plen;
        logic        known;
        logic [2:0]  status;
        logic        allowed;
    } t_probe;

    // A subnet that random traffic reuses to hit existing rules.
    typedef struct packed {
        logic         deny;
        logic         v6;
        logic [7:0]   plen;
        logic [127:0] addr;
    } t_subnet;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        start            = 1'b0;
    logic        busy;
    logic [2:0]  i_req_type       = REQ_CHECK;
    logic        i_is_ipv6        = 1'b0;
    logic [63:0] i_addr_high      = '0;
    logic [63:0] i_addr_low       = '0;
    logic [7:0]  i_prefix_len     = '0;
    logic        o_done;
    logic [2:0]  o_status;
    logic        o_access_allowed;

    subnet_access_rule_table uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_is_ipv6        (i_is_ipv6),
        .i_addr_high      (i_addr_high),
        .i_addr_low       (i_addr_low),
        .i_prefix_len     (i_prefix_len),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_access_allowed (o_access_allowed)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predicted rule table. Addresses are kept as 128-bit words, masked to the prefix;
    // an IPv4 rule lives in bits 31..0 with everything above zero.
    logic         acl_valid [RULE_ENTRIES];
    logic         acl_deny  [RULE_ENTRIES];
    logic         acl_v6    [RULE_ENTRIES];
    logic [7:0]   acl_plen  [RULE_ENTRIES];
    logic [127:0] acl_addr  [RULE_ENTRIES];

    t_verdict expected_verdicts [$];
    t_subnet  subnet_pool [$];
    t_probe   directed_rows [DIRECTED_COUNT];

    int error_count    = 0;
    int items_sent     = 0;
    int stall_cycles   = 0;
    int checks_allowed = 0;
    int checks_denied  = 0;
    int status_tally [8];

    // Network mask for a prefix that is already known to be legal for its family.
    // A shift by the full width yields zero, so /0 and the full-length prefix fall out.
    function automatic logic [127:0] subnet_mask(input logic v6, input logic [7:0] plen);
        logic [31:0] m4;
        m4 = ~(32'hFFFF_FFFF >> plen);
        if (v6)
            return ~({128{1'b1}} >> plen);
        return {96'd0, m4};
    endfunction

    // Applies one request to the predicted table and returns the verdict it must produce.
    function automatic void apply_request(input logic [2:0] req, input logic v6,
                                          input logic [63:0] ah, input logic [63:0] al,
                                          input logic [7:0] plen, output t_verdict v);
        logic [127:0] addr;
        logic [127:0] masked;
        logic         deny;
        logic         is_add;
        logic         hit_allow;
        logic         hit_deny;
        logic [7:0]   best_allow;
        logic [7:0]   best_deny;
        int           match;
        int           slot;
        addr       = v6 ? {ah, al} : {96'd0, al[31:0]};
        v.status   = ST_OK;
        v.allowed  = 1'b0;
        hit_allow  = 1'b0;
        hit_deny   = 1'b0;
        best_allow = '0;
        best_deny  = '0;
        match      = -1;
        slot       = -1;
        if (req == REQ_CHECK) begin
            // Longest allow and longest deny of the same family; a tie goes to deny.
            for (int i = 0; i < RULE_ENTRIES; i++) begin
                if (acl_valid[i] && acl_v6[i] == v6 &&
                    (addr & subnet_mask(v6, acl_plen[i])) == acl_addr[i]) begin
                    if (acl_deny[i]) begin
                        if (!hit_deny || acl_plen[i] > best_deny) best_deny = acl_plen[i];
                        hit_deny = 1'b1;
                    end else begin
                        if (!hit_allow || acl_plen[i] > best_allow) best_allow = acl_plen[i];
                        hit_allow = 1'b1;
                    end
                end
            end
            v.allowed = !hit_deny || (hit_allow && best_allow > best_deny);
        end else if (req <= REQ_DEL_DENY) begin
            deny   = (req == REQ_ADD_DENY) || (req == REQ_DEL_DENY);
            is_add = (req == REQ_ADD_ALLOW) || (req == REQ_ADD_DENY);
            if (plen > (v6 ? V6_MAX_PREFIX : V4_MAX_PREFIX)) begin
                v.status = ST_BAD_PREFIX;
            end else begin
                masked = addr & subnet_mask(v6, plen);
                for (int i = 0; i < RULE_ENTRIES; i++) begin
                    if (match < 0 && acl_valid[i] && acl_deny[i] == deny && acl_v6[i] == v6 &&
                        acl_plen[i] == plen && acl_addr[i] == masked)
                        match = i;
                end
                if (is_add) begin
                    for (int i = 0; i < RULE_ENTRIES; i++) begin
                        if (slot < 0 && !acl_valid[i]) slot = i;
                    end
                    if (match >= 0) begin
                        v.status = ST_PRESENT;
                    end else if (slot < 0) begin
                        v.status = ST_FULL;
                    end else begin
                        acl_valid[slot] = 1'b1;
                        acl_deny[slot]  = deny;
                        acl_v6[slot]    = v6;
                        acl_plen[slot]  = plen;
                        acl_addr[slot]  = masked;
                    end
                end else if (match >= 0) begin
                    acl_valid[match] = 1'b0;
                end else begin
                    v.status = ST_NOT_FOUND;
                end
            end
        end
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Idle cycles before the next item: each cycle is idle with the given chance in 100.
    function automatic int idle_gap(input int pct);
        int n;
        n = 0;
        while (n < 100 && $urandom_range(99) < pct) n++;
        return n;
    endfunction

    // Prefix lengths lean toward the two extremes of the family.
    function automatic logic [7:0] pick_prefix(input logic v6);
        int unsigned top;
        int unsigned roll;
        top  = v6 ? V6_MAX_PREFIX : V4_MAX_PREFIX;
        roll = $urandom_range(9);
        if (roll == 0) return 8'd0;
        if (roll == 1) return 8'(top);
        return 8'($urandom_range(top));
    endfunction

    // An address inside the given subnet with random host bits.
    function automatic logic [127:0] any_host(input t_subnet s);
        logic [127:0] m;
        m = subnet_mask(s.v6, s.plen);
        return (s.addr & m) | ({rand64(), rand64()} & ~m);
    endfunction

    // Presents one item after an idle gap, holds it until the block takes it, then
    // records the verdict to wait for. Called just after a rising edge.
    task automatic issue_request(input logic [2:0] req, input logic v6,
                                 input logic [63:0] ah, input logic [63:0] al,
                                 input logic [7:0] plen, input int gap,
                                 input logic known, input t_verdict known_v);
        t_verdict v;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_req_type   <= req;
        i_is_ipv6    <= v6;
        i_addr_high  <= ah;
        i_addr_low   <= al;
        i_prefix_len <= plen;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_request(req, v6, ah, al, plen, v);
        if (known) v = known_v;
        expected_verdicts = {expected_verdicts, v};
        items_sent++;
        status_tally[v.status]++;
        if (req == REQ_CHECK) begin
            if (v.allowed) checks_allowed++;
            else checks_denied++;
        end
    endtask

    // Random traffic. Most adds, deletes and checks reuse a recent subnet so that
    // duplicates, nested prefixes and real matches are common; the rest is noise.
    task automatic random_request(input int add_pct, input int del_pct, input int gap);
        logic [2:0]   req;
        logic         v6;
        logic [127:0] addr;
        logic [7:0]   plen;
        t_subnet      s;
        t_subnet      fresh;
        logic         from_pool;
        int           roll;
        roll      = $urandom_range(99);
        v6        = 1'($urandom_range(1));
        addr      = {rand64(), rand64()};
        plen      = pick_prefix(v6);
        s         = '0;
        from_pool = (subnet_pool.size() != 0) && ($urandom_range(99) < 75);
        if (from_pool) s = subnet_pool[$urandom_range(subnet_pool.size() - 1)];
        if (roll < 4) begin
            req = REQ_RESERVED_A + 3'($urandom_range(REQ_RESERVED_Z - REQ_RESERVED_A));
        end else if (roll < 8) begin
            req = 3'($urandom_range(REQ_DEL_DENY));
            v6  = ($urandom_range(3) == 0);
            if (v6) plen = 8'($urandom_range(V6_MAX_PREFIX + 1, 255));
            else plen = 8'($urandom_range(V4_MAX_PREFIX + 1, V6_MAX_PREFIX));
        end else if (roll < 8 + add_pct) begin
            req = $urandom_range(1) ? REQ_ADD_DENY : REQ_ADD_ALLOW;
            if (from_pool) begin
                v6   = s.v6;
                addr = any_host(s);
                plen = $urandom_range(1) ? s.plen : pick_prefix(v6);
            end
            fresh.deny  = (req == REQ_ADD_DENY);
            fresh.v6    = v6;
            fresh.plen  = plen;
            fresh.addr  = addr & subnet_mask(v6, plen);
            subnet_pool = {subnet_pool, fresh};
            if (subnet_pool.size() > POOL_DEPTH) void'(subnet_pool.pop_front());
        end else if (roll < 8 + add_pct + del_pct) begin
            req = $urandom_range(1) ? REQ_DEL_DENY : REQ_DEL_ALLOW;
            if (from_pool) begin
                req  = s.deny ? REQ_DEL_DENY : REQ_DEL_ALLOW;
                v6   = s.v6;
                plen = s.plen;
                addr = any_host(s);
            end
        end else begin
            req = REQ_CHECK;
            if (from_pool) begin
                v6   = s.v6;
                addr = any_host(s);
            end
            plen = 8'($urandom);
        end
        // IPv4 usually comes with clean upper bits, but junk there must be ignored.
        if (!v6 && $urandom_range(3) != 0) addr[127:32] = '0;
        issue_request(req, v6, addr[127:64], addr[63:0], plen, gap, 1'b0, '0);
    endtask

    // Results are taken at the edge that ends their strobe cycle and matched in order.
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_done) begin
            if (expected_verdicts.size() == 0) begin
                $display("%0t: unexpected result, status %0d allowed %0b",
                         $time, o_status, o_access_allowed);
                error_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, o_status);
                    error_count++;
                end
                if (o_access_allowed !== want.allowed) begin
                    $display("%0t: access_allowed mismatch, expected %0b actual %0b",
                             $time, want.allowed, o_access_allowed);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any accepted item or result restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, stall_cycles, expected_verdicts.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int       idle_pct;
        int       phase;
        logic     filling;
        t_verdict v;
        for (int i = 0; i < RULE_ENTRIES; i++) acl_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++) status_tally[i] = 0;

        // Directed rows: IPv4 nesting and tie-breaks under 10.0.0.0/8, junk in the unused
        // IPv4 bits, duplicates, misses, bad prefixes of both families, /0 and full-length
        // rules, an ignored prefix on a check, and reserved request codes.
        directed_rows = '{
            '{REQ_CHECK,     1'b0, 64'd0, 64'd0,                  8'd0,   1'b1, ST_OK, 1'b1},
            '{REQ_ADD_DENY,  1'b0, 64'd0, 64'h0A00_0000,          8'd8,   1'b1, ST_OK, 1'b0},
            '{REQ_CHECK,     1'b0, 64'd0, 64'h0A01_0203,          8'd255, 1'b1, ST_OK, 1'b0},
            '{REQ_ADD_ALLOW, 1'b0, 64'd0, 64'h0A01_0000,          8'd16,  1'b1, ST_OK, 1'b0},
            '{REQ_CHECK,     1'b0, 64'd0, 64'h0A01_0203,          8'd0,   1'b1, ST_OK, 1'b1},
            '{REQ_ADD_ALLOW, 1'b0, '1,    64'hFFFF_FFFF_0A77_1234, 8'd8,  1'b1, ST_OK, 1'b0},
            '{REQ_CHECK,     1'b0, 64'd0, 64'h0A09_0909,          8'd0,   1'b1, ST_OK, 1'b0},
            '{REQ_ADD_ALLOW, 1'b0, 64'd0, 64'h0A00_0000,          8'd8,   1'b1, ST_PRESENT, 1'b0},
            '{REQ_ADD_DENY,  1'b0, 64'd0, 64'd0,                  8'd33,  1'b1, ST_BAD_PREFIX, 1'b0},
            '{REQ_DEL_ALLOW, 1'b0, 64'd0, 64'h0A01_FFFF,          8'd16,  1'b1, ST_OK, 1'b0},
            '{REQ_DEL_ALLOW, 1'b0, 64'd0, 64'h0A01_0000,          8'd16,  1'b1, ST_NOT_FOUND, 1'b0},
            '{REQ_ADD_DENY,  1'b0, 64'd0, '1,                     8'd0,   1'b1, ST_OK, 1'b0},
            '{REQ_CHECK,     1'b0, '1,    '1,                     8'd0,   1'b1, ST_OK, 1'b0},
            '{REQ_ADD_ALLOW, 1'b0, 64'd0, 64'hFFFF_FFFF,          8'd32,  1'b1, ST_OK, 1'b0},
            '{REQ_CHECK,     1'b0, 64'd0, 64'hFFFF_FFFF,          8'd0,   1'b1, ST_OK, 1'b1},
            '{REQ_ADD_ALLOW, 1'b1, '1,    '1,                     8'd128, 1'b1, ST_OK, 1'b0},
            '{REQ_ADD_DENY,  1'b1, '1,    '1,                     8'd0,   1'b1, ST_OK, 1'b0},
            '{REQ_CHECK,     1'b1, '1,    '1,                     8'd0,   1'b1, ST_OK, 1'b1},
            '{REQ_CHECK,     1'b1, 64'd0, 64'd0,                  8'd0,   1'b1, ST_OK, 1'b0},
            '{REQ_ADD_ALLOW, 1'b1, 64'd0, 64'd0,                  8'd200, 1'b1, ST_BAD_PREFIX, 1'b0},
            '{REQ_DEL_DENY,  1'b1, 64'h2001_0DB8_0000_0000, 64'd0, 8'd64, 1'b1, ST_NOT_FOUND, 1'b0},
            '{REQ_ADD_DENY,  1'b1, 64'h2001_0DB8_0000_0000, 64'h1234, 8'd64, 1'b0, ST_OK, 1'b0},
            '{REQ_ADD_ALLOW, 1'b1, 64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0000, 8'd65,
              1'b0, ST_OK, 1'b0},
            '{REQ_CHECK,     1'b1, 64'h2001_0DB8_0000_0000, 64'h8000_0000_0000_0001, 8'd0,
              1'b0, ST_OK, 1'b0},
            '{REQ_RESERVED_A, 1'b0, 64'd0, 64'h0A00_0001,         8'd8,   1'b1, ST_OK, 1'b0},
            '{REQ_RESERVED_Z, 1'b1, '1,    '1,                    8'd128, 1'b1, ST_OK, 1'b0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            v.status  = directed_rows[r].status;
            v.allowed = directed_rows[r].allowed;
            issue_request(directed_rows[r].req, directed_rows[r].v6,
                          directed_rows[r].addr_high, directed_rows[r].addr_low,
                          directed_rows[r].plen, 0, directed_rows[r].known, v);
        end

        // Random part: the sender idling rate changes every 70 items, and the traffic
        // swings between filling the table and draining it every 120 items.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            phase    = (n / 70) % 3;
            idle_pct = (phase == 1) ? 87 : (phase == 2) ? 35 : 0;
            filling  = ((n / 120) % 2) == 0;
            random_request(filling ? 50 : 15, filling ? 8 : 40, idle_gap(idle_pct));
        end

        start <= 1'b0;
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d items: %0d ok, %0d duplicate, %0d missing, %0d table-full, %0d %s",
                 items_sent, status_tally[ST_OK], status_tally[ST_PRESENT],
                 status_tally[ST_NOT_FOUND], status_tally[ST_FULL],
                 status_tally[ST_BAD_PREFIX], "bad-prefix results");
        $display("Address checks: %0d allowed, %0d denied.", checks_allowed, checks_denied);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
